[sv/wbst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbst_pkg
// Types, codes and pattern functions for the walking-bit RAM self-test unit.
// ----------------------------------------------------------------------------
package wbst_pkg;

    // Request kinds carried in the req_type field.
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_SWEEP = 2'd3;

    // Fault codes.
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_SWEEP = 2'd1;
    localparam logic [1:0] FAULT_TICK  = 2'd2;

    // Number of pattern steps: walking one then walking zero over 16 bits.
    localparam logic [5:0] STEPS     = 6'd32;
    localparam logic [5:0] LAST_STEP = 6'd31;

    typedef logic [11:0] cell_idx_t;
    typedef logic [10:0] partner_idx_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [10:0] address;
        logic [15:0] write_data;
    } item_t;

    typedef struct packed {
        logic [15:0]  read_data;
        logic [1:0]   fault_code;
        cell_idx_t    cell_index;
        partner_idx_t partner_index;
        logic [5:0]   pattern_step;
    } result_t;

    // Handshake status from the test engine to the port logic.
    typedef struct packed {
        logic idle;
        logic done;
    } status_t;

    // Walking one for steps 0 to 15, walking zero for steps 16 to 31.
    function automatic logic [15:0] walk_pattern(input logic [4:0] s);
        logic [15:0] b;
        b = 16'h0001 << s[3:0];
        return s[4] ? ~b : b;
    endfunction

    // Background written to the partner word.
    function automatic logic [15:0] background_word(input logic [4:0] s);
        return s[4] ? 16'hFFFF : 16'h0000;
    endfunction

endpackage

[sv/wbst_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbst_ram
// Single-port word memory with a registered read port (read-first).
// ----------------------------------------------------------------------------
module wbst_ram #(
    parameter int WORDS = 2048
) (
    input  logic                     clk,
    input  logic [$clog2(WORDS)-1:0] addr,
    input  logic                     we,
    input  logic [15:0]              wdata,
    output logic [15:0]              rdata
);

    logic [15:0] mem [WORDS];
    logic [15:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/wbst_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbst_engine
// Sequencer that clears the memory, serves host accesses and runs the
// coupling test step and the startup sweep through the single memory port.
// ----------------------------------------------------------------------------
module wbst_engine #(
    parameter int WORDS = 2048
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  wbst_pkg::item_t          item,
    input  logic                     taken,
    output wbst_pkg::status_t        status,
    output wbst_pkg::result_t        result,
    output logic [$clog2(WORDS)-1:0] ram_addr,
    output logic                     ram_we,
    output logic [15:0]              ram_wdata,
    input  logic [15:0]              ram_rdata
);

    localparam int AW = $clog2(WORDS);
    localparam int CW = $clog2(WORDS + 1);

    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] cell_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_T_RDC,
        S_T_RDP,
        S_T_WRP,
        S_T_WRC,
        S_T_CHKP,
        S_T_CHKC,
        S_T_RSTP,
        S_T_RSTC,
        S_SW_RD,
        S_SW_SAVE,
        S_SW_WR,
        S_SW_CHKRD,
        S_SW_CMP,
        S_SW_RSTR,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    addr_t           clr_reg, clr_next;
    wbst_pkg::item_t item_reg, item_next;
    cell_t           cell_reg, cell_next;
    addr_t           partner_reg, partner_next;
    logic [5:0]      step_reg, step_next;
    logic [1:0]      fault_reg, fault_next;
    logic [15:0]     rd_reg, rd_next;
    logic [15:0]     save_c_reg, save_c_next;
    logic [15:0]     save_p_reg, save_p_next;
    logic            err_reg, err_next;

    logic            host_ok;
    addr_t           host_addr;
    addr_t           cell_addr;
    cell_t           cell_inc;
    logic [15:0]     wp;
    logic [15:0]     bg;

    assign host_ok   = 32'(item_reg.address) < WORDS;
    assign host_addr = addr_t'(item_reg.address);
    assign cell_addr = cell_reg[AW-1:0];
    assign cell_inc  = cell_reg + cell_t'(1);
    assign wp        = wbst_pkg::walk_pattern(step_reg[4:0]);
    assign bg        = wbst_pkg::background_word(step_reg[4:0]);

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        item_next    = item_reg;
        cell_next    = cell_reg;
        partner_next = partner_reg;
        step_next    = step_reg;
        fault_next   = fault_reg;
        rd_next      = rd_reg;
        save_c_next  = save_c_reg;
        save_p_next  = save_p_reg;
        err_next     = err_reg;
        ram_addr     = cell_addr;
        ram_we       = 1'b0;
        ram_wdata    = 16'h0000;

        case (state_reg)
            S_CLEAR:
            begin
                ram_addr = clr_reg;
                ram_we   = 1'b1;
                if (clr_reg == addr_t'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + addr_t'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                rd_next    = 16'h0000;
                state_next = S_DONE;
                case (item_reg.req_type)
                    wbst_pkg::REQ_READ:
                    begin
                        if (host_ok)
                        begin
                            ram_addr   = host_addr;
                            state_next = S_RD_WAIT;
                        end
                    end
                    wbst_pkg::REQ_WRITE:
                    begin
                        ram_addr  = host_addr;
                        ram_wdata = item_reg.write_data;
                        ram_we    = host_ok;
                    end
                    wbst_pkg::REQ_TICK:
                    begin
                        if (fault_reg != wbst_pkg::FAULT_NONE)
                        begin
                            state_next = S_DONE;
                        end
                        else if (cell_reg >= cell_t'(WORDS))
                        begin
                            // Test restarts from the first cell.
                            cell_next    = '0;
                            partner_next = addr_t'(1);
                        end
                        else if (cell_t'(partner_reg) != cell_reg)
                        begin
                            // The partner index always lies inside the memory.
                            if (step_reg < wbst_pkg::STEPS)
                            begin
                                err_next   = 1'b0;
                                state_next = S_T_RDC;
                            end
                            else
                            begin
                                step_next = '0;
                                if (partner_reg < addr_t'(WORDS - 1))
                                begin
                                    partner_next = partner_reg + addr_t'(1);
                                end
                                else
                                begin
                                    partner_next = '0;
                                end
                            end
                        end
                        else
                        begin
                            cell_next = cell_inc;
                            if (cell_inc < cell_t'(WORDS - 1))
                            begin
                                partner_next = addr_t'(cell_inc + cell_t'(1));
                            end
                            else
                            begin
                                partner_next = '0;
                            end
                        end
                    end
                    default:
                    begin
                        if (fault_reg == wbst_pkg::FAULT_NONE)
                        begin
                            cell_next  = '0;
                            state_next = S_SW_RD;
                        end
                    end
                endcase
            end

            S_RD_WAIT:
            begin
                rd_next    = ram_rdata;
                state_next = S_DONE;
            end

            // Coupling test step: save both words, write background and
            // pattern, read both back, restore both.
            S_T_RDC:
            begin
                state_next = S_T_RDP;
            end

            S_T_RDP:
            begin
                ram_addr    = partner_reg;
                save_c_next = ram_rdata;
                state_next  = S_T_WRP;
            end

            S_T_WRP:
            begin
                ram_addr    = partner_reg;
                ram_we      = 1'b1;
                ram_wdata   = bg;
                save_p_next = ram_rdata;
                state_next  = S_T_WRC;
            end

            S_T_WRC:
            begin
                ram_we     = 1'b1;
                ram_wdata  = wp;
                state_next = S_T_CHKP;
            end

            S_T_CHKP:
            begin
                ram_addr   = partner_reg;
                state_next = S_T_CHKC;
            end

            S_T_CHKC:
            begin
                err_next   = ram_rdata != bg;
                state_next = S_T_RSTP;
            end

            S_T_RSTP:
            begin
                err_next   = err_reg | (ram_rdata != wp);
                ram_addr   = partner_reg;
                ram_we     = 1'b1;
                ram_wdata  = save_p_reg;
                state_next = S_T_RSTC;
            end

            S_T_RSTC:
            begin
                ram_we     = 1'b1;
                ram_wdata  = save_c_reg;
                state_next = S_DONE;
                if (err_reg)
                begin
                    fault_next = wbst_pkg::FAULT_TICK;
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end

            // Sweep: all 32 patterns per word until a mismatch, then restored.
            S_SW_RD:
            begin
                step_next  = '0;
                err_next   = 1'b0;
                state_next = S_SW_SAVE;
            end

            S_SW_SAVE:
            begin
                save_c_next = ram_rdata;
                state_next  = S_SW_WR;
            end

            S_SW_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = wp;
                state_next = S_SW_CHKRD;
            end

            S_SW_CHKRD:
            begin
                state_next = S_SW_CMP;
            end

            S_SW_CMP:
            begin
                if (ram_rdata != wp)
                begin
                    err_next   = 1'b1;
                    fault_next = wbst_pkg::FAULT_SWEEP;
                    state_next = S_SW_RSTR;
                end
                else if (step_reg == wbst_pkg::LAST_STEP)
                begin
                    step_next  = wbst_pkg::STEPS;
                    state_next = S_SW_RSTR;
                end
                else
                begin
                    step_next  = step_reg + 6'd1;
                    state_next = S_SW_WR;
                end
            end

            S_SW_RSTR:
            begin
                ram_we    = 1'b1;
                ram_wdata = save_c_reg;
                if (err_reg)
                begin
                    state_next = S_DONE;
                end
                else if (cell_reg == cell_t'(WORDS - 1))
                begin
                    cell_next  = cell_t'(WORDS);
                    state_next = S_DONE;
                end
                else
                begin
                    cell_next  = cell_inc;
                    state_next = S_SW_RD;
                end
            end

            S_DONE:
            begin
                if (taken)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            cell_reg    <= cell_t'(WORDS);
            partner_reg <= '0;
            step_reg    <= '0;
            fault_reg   <= wbst_pkg::FAULT_NONE;
            err_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cell_reg    <= cell_next;
            partner_reg <= partner_next;
            step_reg    <= step_next;
            fault_reg   <= fault_next;
            err_reg     <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        rd_reg     <= rd_next;
        save_c_reg <= save_c_next;
        save_p_reg <= save_p_next;
    end

    assign status.idle = state_reg == S_IDLE;
    assign status.done = state_reg == S_DONE;

    assign result.read_data     = rd_reg;
    assign result.fault_code    = fault_reg;
    assign result.cell_index    = wbst_pkg::cell_idx_t'(cell_reg);
    assign result.partner_index = wbst_pkg::partner_idx_t'(partner_reg);
    assign result.pattern_step  = step_reg;

endmodule

[sv/walking_bit_ram_self_test_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// walking_bit_ram_self_test_unit
// Word memory with host access and a built-in walking-bit self-test.
// ----------------------------------------------------------------------------
// After reset the unit clears its memory, one word per cycle, and stalls
// requests until the clearing pass is done. Each request then gives
// exactly one response. All work goes through one single-port memory
// with a registered read port. A test tick that exercises a cell and its
// partner makes eight memory accesses, other ticks write nothing, and a
// startup sweep saves every word, writes and reads it back with all 32
// patterns and then restores it, stopping at the first mismatch. One
// request is worked on at a time; a finished response waits in the output
// register, so the next request can be accepted while the response is
// still stalled. Once a fault is latched, ticks and sweeps no longer
// touch the memory, whereas host reads and writes carry on as normal.
// ----------------------------------------------------------------------------
module walking_bit_ram_self_test_unit #(
    parameter int WORDS = 2048
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  wbst_pkg::item_t   req_data,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output wbst_pkg::result_t rsp_data
);

    localparam int AW = $clog2(WORDS);

    wbst_pkg::status_t status;
    wbst_pkg::result_t result;
    logic              start;
    logic              taken;
    logic [AW-1:0]     ram_addr;
    logic              ram_we;
    logic [15:0]       ram_wdata;
    logic [15:0]       ram_rdata;

    logic              rsp_valid_reg, rsp_valid_next;
    wbst_pkg::result_t rsp_data_reg, rsp_data_next;

    // A request is taken only while the engine is idle; the clearing pass
    // and any request in progress hold the stall high.
    assign req_stall = !status.idle;
    assign start     = req_valid && !req_stall;

    // The finished response moves into the output register when it is empty
    // or being emptied in this cycle.
    assign taken = status.done && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (taken)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = result;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    wbst_engine #(
        .WORDS (WORDS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (req_data),
        .taken     (taken),
        .status    (status),
        .result    (result),
        .ram_addr  (ram_addr),
        .ram_we    (ram_we),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    wbst_ram #(
        .WORDS (WORDS)
    ) u_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule
